[rtl/sbe_pkg.sv]
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, constants and the phase program of the SBE response parser.
// ----------------------------------------------------------------------------
`default_nettype none
package sbe_pkg;

  localparam int unsigned FixedStringBytes = 64;
  localparam logic [15:0] SchemaReset = 16'd2;
  localparam logic [15:0] AuthMin  = 16'(2 * FixedStringBytes + 4);
  localparam logic [15:0] PongMin  = 16'd16;
  localparam logic [15:0] OrderMin = 16'(5 * FixedStringBytes + 44);
  localparam logic [15:0] BatchMin = 16'(3 * FixedStringBytes + 44);
  localparam logic [15:0] CerrMin  = 16'(3 * FixedStringBytes + 44);
  localparam logic [15:0] ItemMin  = 16'(2 * FixedStringBytes + 13);
  localparam logic [15:0] FixLast  = 16'(FixedStringBytes);

  // phase numbers that the control logic names
  localparam logic [4:0] PhHdr       = 5'd0;
  localparam logic [4:0] PhAuthReq   = 5'd1;
  localparam logic [4:0] PhBlkSkip   = 5'd4;
  localparam logic [4:0] PhRetLen    = 5'd5;
  localparam logic [4:0] PhRetMsg    = 5'd6;
  localparam logic [4:0] PhPongTs    = 5'd7;
  localparam logic [4:0] PhOrdReq    = 5'd9;
  localparam logic [4:0] PhRetCode   = 5'd17;
  localparam logic [4:0] PhOrderId   = 5'd18;
  localparam logic [4:0] PhItemBlk   = 5'd20;
  localparam logic [4:0] PhItemCnt   = 5'd21;
  localparam logic [4:0] PhItemFirst = 5'd22;
  localparam logic [4:0] PhItemSkip  = 5'd27;
  localparam logic [4:0] PhItemLen   = 5'd28;
  localparam logic [4:0] PhItemMsg   = 5'd29;
  localparam logic [4:0] PhEnd       = 5'd31;

  typedef enum logic [2:0] {
    StHdr, StNum, StFix, StSkip, StVlen, StVstr, StEnd
  } step_kind_t;

  typedef enum logic [2:0] {
    ErrNone = 3'd0, ErrTrunc = 3'd1, ErrSchema = 3'd2, ErrTemplate = 3'd3,
    ErrShort = 3'd4, ErrItemShort = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    KAuth = 3'd0, KPong = 3'd1, KOrder = 3'd2, KBatch = 3'd3, KCerr = 3'd4,
    KNone = 3'd7
  } kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [3:0] size;
    logic [4:0] code;
    logic [4:0] nxt;
  } step_t;

  // one result word
  typedef struct packed {
    logic [4:0]  field_code;
    logic [63:0] value;
    logic        string_byte;
    logic [15:0] char_index;
    logic [2:0]  message_kind;
    logic [15:0] item_index;
    logic        end_of_message;
    logic [2:0]  error;
  } result_t;

  function automatic step_t prog(input logic [4:0] p);
    step_t s;
    s = '{StEnd, 4'd0, 5'd0, 5'd31};
    unique case (p)
      5'd0:  s = '{StHdr, 4'd8, 5'd1, 5'd0};
      5'd1:  s = '{StFix, 4'd0, 5'd2, 5'd2};
      5'd2:  s = '{StNum, 4'd4, 5'd3, 5'd3};
      5'd3:  s = '{StFix, 4'd0, 5'd4, 5'd4};
      5'd4:  s = '{StSkip, 4'd0, 5'd0, 5'd5};
      5'd5:  s = '{StVlen, 4'd2, 5'd5, 5'd6};
      5'd6:  s = '{StVstr, 4'd0, 5'd6, 5'd31};
      5'd7:  s = '{StNum, 4'd8, 5'd7, 5'd8};
      5'd8:  s = '{StNum, 4'd8, 5'd8, 5'd31};
      5'd9:  s = '{StFix, 4'd0, 5'd2, 5'd10};
      5'd10: s = '{StFix, 4'd0, 5'd4, 5'd11};
      5'd11: s = '{StFix, 4'd0, 5'd9, 5'd12};
      5'd12: s = '{StNum, 4'd8, 5'd10, 5'd13};
      5'd13: s = '{StNum, 4'd8, 5'd11, 5'd14};
      5'd14: s = '{StNum, 4'd8, 5'd12, 5'd15};
      5'd15: s = '{StNum, 4'd8, 5'd13, 5'd16};
      5'd16: s = '{StNum, 4'd8, 5'd14, 5'd17};
      5'd17: s = '{StNum, 4'd4, 5'd3, 5'd4};
      5'd18: s = '{StFix, 4'd0, 5'd15, 5'd19};
      5'd19: s = '{StFix, 4'd0, 5'd16, 5'd4};
      5'd20: s = '{StNum, 4'd2, 5'd17, 5'd21};
      5'd21: s = '{StNum, 4'd2, 5'd18, 5'd22};
      5'd22: s = '{StNum, 4'd4, 5'd19, 5'd23};
      5'd23: s = '{StNum, 4'd1, 5'd20, 5'd24};
      5'd24: s = '{StNum, 4'd8, 5'd21, 5'd25};
      5'd25: s = '{StFix, 4'd0, 5'd22, 5'd26};
      5'd26: s = '{StFix, 4'd0, 5'd23, 5'd27};
      5'd27: s = '{StSkip, 4'd0, 5'd0, 5'd28};
      5'd28: s = '{StVlen, 4'd2, 5'd24, 5'd29};
      5'd29: s = '{StVstr, 4'd0, 5'd25, 5'd31};
      default: s = '{StEnd, 4'd0, 5'd0, 5'd31};
    endcase
    return s;
  endfunction

  function automatic kind_t kind_of(input logic [15:0] t);
    kind_t k;
    unique case (t)
      16'd2:                  k = KAuth;
      16'd4:                  k = KPong;
      16'd6, 16'd8, 16'd10:   k = KOrder;
      16'd12, 16'd14, 16'd16: k = KBatch;
      16'd17:                 k = KCerr;
      default:                k = KNone;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] min_block(input kind_t k);
    logic [15:0] m;
    unique case (k)
      KAuth:   m = AuthMin;
      KPong:   m = PongMin;
      KOrder:  m = OrderMin;
      KBatch:  m = BatchMin;
      KCerr:   m = CerrMin;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/sbe_core.sv]
// ----------------------------------------------------------------------------
// sbe_core
// Per-byte parser state and next-state logic; produces at most one result
// word per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none
module sbe_core
  import sbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] schema,
  output logic             res_have,
  output result_t          res
);

  logic [4:0]  phase, phase_next;
  logic [15:0] fcnt, fcnt_next;
  logic [63:0] acc, acc_next;
  logic [15:0] blk, blk_next;
  logic [15:0] tmpl, tmpl_next;
  logic [15:0] skip, skip_next;
  logic [15:0] iblk, iblk_next;
  logic [15:0] irem, irem_next;
  logic [15:0] icnt, icnt_next;
  logic        nul, nul_next;
  logic        done, done_next;

  // resolve an entered phase; chained entries collapse to a few muxes
  function automatic void do_enter(
    input  logic [4:0]  p,
    input  logic [15:0] blk_v, tmpl_v, iblk_v, skip_in, irem_in, icnt_in,
    output logic [4:0]  p_o,
    output logic [15:0] skip_o, irem_o, icnt_o,
    output logic        done_o
  );
    logic [4:0]  q;
    logic [15:0] sk, ir, ic;
    logic        dn;
    q = p; sk = skip_in; ir = irem_in; ic = icnt_in; dn = 1'b0;
    if (q == PhBlkSkip) begin
      sk = blk_v - min_block(kind_of(tmpl_v));
      if (sk == 16'd0) q = (kind_of(tmpl_v) == KBatch) ? PhItemBlk : PhRetLen;
    end else if (q == PhItemSkip) begin
      sk = iblk_v - ItemMin;
      if (sk == 16'd0) q = PhItemLen;
    end else if (q == PhRetMsg && sk == 16'd0) begin
      q = PhEnd;
    end else if (q == PhItemMsg && sk == 16'd0) begin
      ir = ir - 16'd1;
      ic = ic + 16'd1;
      q = (ir != 16'd0) ? PhItemFirst : PhRetLen;
    end
    if (q >= 5'd30) dn = 1'b1;
    p_o = q; skip_o = sk; irem_o = ir; icnt_o = ic; done_o = dn;
  endfunction

  step_t       s;
  logic        have, isstr, in_item, entering;
  logic [4:0]  ent_p, ent_q;
  err_t        err;
  logic [4:0]  code;
  logic [63:0] val;
  logic [15:0] ci, ii, cnt1, ent_skip_in, ent_irem_in, ent_icnt_in;
  logic [15:0] e_skip, e_irem, e_icnt;
  logic        e_done;
  kind_t       kd;
  logic [2:0]  kind_o;

  // decode one byte
  always_comb begin
    s = prog(phase);
    in_item = (phase >= PhItemFirst) && (phase <= PhItemMsg);
    have = 1'b0; isstr = 1'b0; err = ErrNone; code = '0; val = '0;
    ci = '0; ii = '0; entering = 1'b0; ent_p = PhHdr;
    kd = kind_of(tmpl);
    phase_next = phase; fcnt_next = fcnt; acc_next = acc; blk_next = blk;
    tmpl_next = tmpl; skip_next = skip; iblk_next = iblk; irem_next = irem;
    icnt_next = icnt; nul_next = nul; done_next = done;
    cnt1 = fcnt + 16'd1;
    if (!done) begin
      unique case (s.kind)
        StHdr: begin
          unique case (fcnt[2:0])
            3'd0: blk_next = {8'd0, data_byte};
            3'd1: blk_next = {data_byte, blk[7:0]};
            3'd2: tmpl_next = {8'd0, data_byte};
            3'd3: tmpl_next = {data_byte, tmpl[7:0]};
            3'd4: acc_next = {56'd0, data_byte};
            3'd5: acc_next = acc | {48'd0, data_byte, 8'd0};
            default: ;
          endcase
          fcnt_next = cnt1;
          if (cnt1 >= 16'd8) begin
            kd = kind_of(tmpl);
            if (acc[15:0] != schema) err = ErrSchema;
            else if (kd == KNone) err = ErrTemplate;
            else if (blk < min_block(kd)) err = ErrShort;
            else begin
              have = 1'b1; code = 5'd1; val = {48'd0, tmpl};
              entering = 1'b1;
              ent_p = (kd == KAuth) ? PhAuthReq : ((kd == KPong) ? PhPongTs : PhOrdReq);
            end
          end
        end
        StNum, StVlen: begin
          acc_next = acc | ({56'd0, data_byte} << {fcnt[2:0], 3'b000});
          fcnt_next = cnt1;
          if (cnt1 >= {12'd0, s.size}) begin
            have = 1'b1; code = s.code; val = acc_next;
            if (in_item) ii = icnt;
            entering = 1'b1;
            if (phase == PhItemBlk) begin
              iblk_next = acc_next[15:0];
              ent_p = PhItemCnt;
            end else if (phase == PhItemCnt) begin
              if (acc_next != 64'd0 && iblk < ItemMin) begin
                err = ErrItemShort; entering = 1'b0;
              end else begin
                irem_next = acc_next[15:0];
                icnt_next = 16'd0;
                ent_p = (acc_next != 64'd0) ? PhItemFirst : PhRetLen;
              end
            end else if (s.kind == StVlen) begin
              skip_next = acc_next[15:0];
              ent_p = s.nxt;
            end else if (phase == PhRetCode) begin
              ent_p = (kind_of(tmpl) == KOrder) ? PhOrderId : PhBlkSkip;
            end else begin
              ent_p = s.nxt;
            end
          end
        end
        StFix: begin
          if (!nul) begin
            if (data_byte == 8'd0) nul_next = 1'b1;
            else begin
              have = 1'b1; code = s.code; val = {56'd0, data_byte}; isstr = 1'b1;
              ci = fcnt;
              if (in_item) ii = icnt;
            end
          end
          fcnt_next = cnt1;
          if (cnt1 >= FixLast) begin
            entering = 1'b1; ent_p = s.nxt;
          end
        end
        StSkip: begin
          if (skip != 16'd0) skip_next = skip - 16'd1;
          if (skip_next == 16'd0) begin
            entering = 1'b1;
            ent_p = (phase == PhBlkSkip) ?
              ((kind_of(tmpl) == KBatch) ? PhItemBlk : PhRetLen) : s.nxt;
          end
        end
        StVstr: begin
          have = 1'b1; code = s.code; val = {56'd0, data_byte}; isstr = 1'b1;
          ci = fcnt;
          if (in_item) ii = icnt;
          fcnt_next = cnt1;
          if (skip != 16'd0) skip_next = skip - 16'd1;
          if (skip_next == 16'd0) begin
            entering = 1'b1;
            if (phase == PhRetMsg) ent_p = PhEnd;
            else begin
              // item done
              irem_next = irem - 16'd1;
              icnt_next = icnt + 16'd1;
              ent_p = (irem_next != 16'd0) ? PhItemFirst : PhRetLen;
            end
          end
        end
        default: done_next = 1'b1;
      endcase
    end
    ent_skip_in = skip_next; ent_irem_in = irem_next; ent_icnt_in = icnt_next;
    do_enter(ent_p, blk_next, tmpl_next, iblk_next, ent_skip_in, ent_irem_in,
             ent_icnt_in, ent_q, e_skip, e_irem, e_icnt, e_done);
    if (!done && entering) begin
      fcnt_next = '0; acc_next = '0; nul_next = 1'b0;
      phase_next = ent_q; skip_next = e_skip; irem_next = e_irem;
      icnt_next = e_icnt;
      if (e_done) done_next = 1'b1;
    end
    if (!done) begin
      if (err == ErrNone && !done_next && last_byte) err = ErrTrunc;
      if (err != ErrNone) begin
        have = 1'b1; done_next = 1'b1;
        code = '0; val = '0; isstr = 1'b0; ci = '0; ii = '0;
      end
    end
    kind_o = kind_of(tmpl_next);
    if ((phase_next == PhHdr && fcnt_next < 16'd8) || kind_o > 3'd4) kind_o = 3'd0;
    res_have = have && !done;
    res = '{field_code: code, value: val, string_byte: isstr, char_index: ci,
            message_kind: kind_o, item_index: ii, end_of_message: done_next,
            error: err};
    // last byte returns to header start
    if (last_byte) begin
      phase_next = PhHdr; fcnt_next = '0; acc_next = '0; blk_next = '0;
      tmpl_next = '0; skip_next = '0; iblk_next = '0; irem_next = '0;
      icnt_next = '0; nul_next = 1'b0; done_next = 1'b0;
    end
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhHdr; fcnt <= '0; acc <= '0; blk <= '0; tmpl <= '0;
      skip <= '0; iblk <= '0; irem <= '0; icnt <= '0; nul <= 1'b0;
      done <= 1'b0;
    end else if (step) begin
      phase <= phase_next; fcnt <= fcnt_next; acc <= acc_next; blk <= blk_next;
      tmpl <= tmpl_next; skip <= skip_next; iblk <= iblk_next;
      irem <= irem_next; icnt <= icnt_next; nul <= nul_next; done <= done_next;
    end
  end

endmodule
`default_nettype wire

[rtl/sbe_order_response_parser.sv]
// Timing: a result word is registered into the output register in the cycle
// after its byte is accepted. Throughput: one byte per cycle while the output
// register is free or drains; a stalled output holds off the input.
// Reset: rst is synchronous; it returns the parser to header start, empties
// the output register and sets the schema register to 2.
`default_nettype none
// ----------------------------------------------------------------------------
// sbe_order_response_parser
// Byte-serial SBE response decoder with one output register.
// ----------------------------------------------------------------------------
module sbe_order_response_parser
  import sbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       field_code,
  output logic [63:0]      value,
  output logic             string_byte,
  output logic [15:0]      char_index,
  output logic [2:0]       message_kind,
  output logic [15:0]      item_index,
  output logic             end_of_message,
  output logic [2:0]       error
);

  logic [15:0] schema;
  logic        step, res_have;
  result_t     res, obuf;

  // accept when the output register is free or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  // hold the schema register
  always_ff @(posedge clk) begin
    if (rst) schema <= SchemaReset;
    else if (cfg_we) schema <= cfg_wdata;
  end

  sbe_core u_core (
    .clk, .rst, .step, .data_byte, .last_byte, .schema, .res_have, .res
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= step && res_have;
  end
  always_ff @(posedge clk) begin
    if (step && res_have) obuf <= res;
  end

  assign field_code     = obuf.field_code;
  assign value          = obuf.value;
  assign string_byte    = obuf.string_byte;
  assign char_index     = obuf.char_index;
  assign message_kind   = obuf.message_kind;
  assign item_index     = obuf.item_index;
  assign end_of_message = obuf.end_of_message;
  assign error          = obuf.error;

`ifndef SYNTHESIS
  a_err_ends : assert property (@(posedge clk) disable iff (rst)
    out_valid && error != 3'd0 |-> end_of_message) else $error("error word not closing");
  a_str_num : assert property (@(posedge clk) disable iff (rst)
    out_valid && error != 3'd0 |-> !string_byte) else $error("string byte on error");
  a_stall : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");
`endif

endmodule
`default_nettype wire

[test/sbe_order_response_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbe_order_response_parser_test
// Drives whole SBE response messages byte by byte into the parser, predicts
// every result word with an in-bench decoder and checks each word in order.
// Covers all templates, error cases, truncation, trailing bytes and several
// schema register settings under random input and output stalls.
// ----------------------------------------------------------------------------
module sbe_order_response_parser_test;
  import sbe_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int TplAuth = 2, TplPong = 4, TplCerr = 17;
  localparam int ByteTarget = 1350, ByteCap = 1400;

  typedef enum logic [4:0] {
    FcError, FcTemplate, FcReqId, FcRetCode, FcConnId, FcRetLen, FcRetMsg,
    FcTimestamp, FcPongTime, FcTraceId, FcTimeNow, FcInTime, FcLimit,
    FcLimitStatus, FcLimitReset, FcOrderId, FcLinkId, FcItemBlk, FcItemCnt,
    FcItemCode, FcItemCat, FcItemSym, FcItemOrderId, FcItemLinkId, FcItemLen,
    FcItemMsg
  } field_id_t;

  typedef enum logic [2:0] {OpHdr, OpNum, OpFix, OpSkip, OpVlen, OpVstr, OpEnd} rule_op_t;
  typedef struct {
    rule_op_t  op;
    int        size;
    field_id_t code;
    logic [4:0] nxt;
  } rule_t;

  logic        clk = 0, rst = 1;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 0, out_ready = 0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 0;
  logic        in_ready, out_valid;
  logic [4:0]  field_code;
  logic [63:0] value;
  logic        string_byte, end_of_message;
  logic [15:0] char_index, item_index;
  logic [2:0]  message_kind, error;

  sbe_order_response_parser dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .data_byte, .last_byte,
    .out_valid, .out_ready, .field_code, .value, .string_byte, .char_index,
    .message_kind, .item_index, .end_of_message, .error
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // decoder copy
  logic [15:0] schema_reg;
  logic [4:0]  ph;
  logic [15:0] fbc, blk, tpl, skip, iblk, irem, icnt;
  logic [63:0] acc;
  logic        nul, done;

  result_t results_due[$];
  logic [7:0] msg_bytes[$];
  int fails = 0, bytes_sent = 0, words_seen = 0, messages_sent = 0, idle_cycles = 0;
  bit no_stall = 0;

  function automatic rule_t rule_of(input logic [4:0] p);
    case (p)
      PhHdr:       return '{OpHdr, 8, FcTemplate, PhHdr};
      PhAuthReq:   return '{OpFix, 0, FcReqId, 5'd2};
      5'd2:        return '{OpNum, 4, FcRetCode, 5'd3};
      5'd3:        return '{OpFix, 0, FcConnId, PhBlkSkip};
      PhBlkSkip:   return '{OpSkip, 0, FcError, PhRetLen};
      PhRetLen:    return '{OpVlen, 2, FcRetLen, PhRetMsg};
      PhRetMsg:    return '{OpVstr, 0, FcRetMsg, PhEnd};
      PhPongTs:    return '{OpNum, 8, FcTimestamp, 5'd8};
      5'd8:        return '{OpNum, 8, FcPongTime, PhEnd};
      PhOrdReq:    return '{OpFix, 0, FcReqId, 5'd10};
      5'd10:       return '{OpFix, 0, FcConnId, 5'd11};
      5'd11:       return '{OpFix, 0, FcTraceId, 5'd12};
      5'd12:       return '{OpNum, 8, FcTimeNow, 5'd13};
      5'd13:       return '{OpNum, 8, FcInTime, 5'd14};
      5'd14:       return '{OpNum, 8, FcLimit, 5'd15};
      5'd15:       return '{OpNum, 8, FcLimitStatus, 5'd16};
      5'd16:       return '{OpNum, 8, FcLimitReset, PhRetCode};
      PhRetCode:   return '{OpNum, 4, FcRetCode, PhBlkSkip};
      PhOrderId:   return '{OpFix, 0, FcOrderId, 5'd19};
      5'd19:       return '{OpFix, 0, FcLinkId, PhBlkSkip};
      PhItemBlk:   return '{OpNum, 2, FcItemBlk, PhItemCnt};
      PhItemCnt:   return '{OpNum, 2, FcItemCnt, PhItemFirst};
      PhItemFirst: return '{OpNum, 4, FcItemCode, 5'd23};
      5'd23:       return '{OpNum, 1, FcItemCat, 5'd24};
      5'd24:       return '{OpNum, 8, FcItemSym, 5'd25};
      5'd25:       return '{OpFix, 0, FcItemOrderId, 5'd26};
      5'd26:       return '{OpFix, 0, FcItemLinkId, PhItemSkip};
      PhItemSkip:  return '{OpSkip, 0, FcError, PhItemLen};
      PhItemLen:   return '{OpVlen, 2, FcItemLen, PhItemMsg};
      PhItemMsg:   return '{OpVstr, 0, FcItemMsg, PhEnd};
      default:     return '{OpEnd, 0, FcError, PhEnd};
    endcase
  endfunction

  function automatic kind_t template_kind(input logic [15:0] t);
    case (t)
      16'd2: return KAuth;
      16'd4: return KPong;
      16'd6, 16'd8, 16'd10: return KOrder;
      16'd12, 16'd14, 16'd16: return KBatch;
      16'd17: return KCerr;
      default: return KNone;
    endcase
  endfunction

  function automatic logic [15:0] block_floor(input kind_t k);
    case (k)
      KAuth: return AuthMin;
      KPong: return PongMin;
      KOrder: return OrderMin;
      KBatch: return BatchMin;
      KCerr: return CerrMin;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [4:0] after_block();
    return (template_kind(tpl) == KBatch) ? PhItemBlk : PhRetLen;
  endfunction

  function automatic logic [4:0] close_item();
    irem = irem - 16'd1;
    icnt = icnt + 16'd1;
    return (irem != 0) ? PhItemFirst : PhRetLen;
  endfunction

  task automatic clear_message();
    ph = PhHdr; fbc = 0; acc = 0; blk = 0; tpl = 0; skip = 0;
    iblk = 0; irem = 0; icnt = 0; nul = 0; done = 0;
  endtask

  // move to a phase, falling through phases with nothing to read
  task automatic enter_phase(input logic [4:0] p0);
    logic [4:0] p;
    bit again;
    p = p0;
    do begin
      again = 0; fbc = 0; acc = 0; nul = 0;
      if (p == PhBlkSkip) begin
        skip = blk - block_floor(template_kind(tpl));
        if (skip == 0) begin p = after_block(); again = 1; end
      end else if (p == PhItemSkip) begin
        skip = iblk - ItemMin;
        if (skip == 0) begin p = PhItemLen; again = 1; end
      end else if (p == PhRetMsg && skip == 0) begin
        p = PhEnd; again = 1;
      end else if (p == PhItemMsg && skip == 0) begin
        p = close_item(); again = 1;
      end else if (p >= 5'd30) begin
        done = 1;
      end
    end while (again);
    ph = p;
  endtask

  // predict the result word, if any, of one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    rule_t r;
    logic [4:0] p;
    bit have, in_item;
    logic [2:0] err;
    field_id_t code;
    logic [63:0] val;
    logic isstr;
    logic [15:0] ci, ii;
    kind_t k;
    result_t w;
    have = 0; err = ErrNone; code = FcError; val = 0; isstr = 0; ci = 0; ii = 0;
    if (!done) begin
      p = ph;
      r = rule_of(p);
      in_item = (p >= PhItemFirst && p <= PhItemMsg);
      case (r.op)
        OpHdr: begin
          case (fbc)
            0: blk = {8'h00, b};
            1: blk[15:8] = b;
            2: tpl = {8'h00, b};
            3: tpl[15:8] = b;
            4: acc = {56'd0, b};
            5: acc[15:8] = b;
            default: ;
          endcase
          fbc = fbc + 16'd1;
          if (fbc >= 8) begin
            k = template_kind(tpl);
            if (acc[15:0] != schema_reg) err = ErrSchema;
            else if (k == KNone) err = ErrTemplate;
            else if (blk < block_floor(k)) err = ErrShort;
            else begin
              have = 1; code = FcTemplate; val = {48'd0, tpl};
              enter_phase(k == KAuth ? PhAuthReq : (k == KPong ? PhPongTs : PhOrdReq));
            end
          end
        end
        OpNum, OpVlen: begin
          acc = acc | ({56'd0, b} << (8 * fbc[2:0]));
          fbc = fbc + 16'd1;
          if (fbc >= r.size) begin
            have = 1; code = r.code; val = acc;
            if (in_item) ii = icnt;
            if (p == PhItemBlk) begin
              iblk = acc[15:0];
              enter_phase(PhItemCnt);
            end else if (p == PhItemCnt) begin
              if (acc != 0 && iblk < ItemMin) err = ErrItemShort;
              else begin
                irem = acc[15:0]; icnt = 0;
                enter_phase(acc != 0 ? PhItemFirst : PhRetLen);
              end
            end else if (r.op == OpVlen) begin
              skip = acc[15:0];
              enter_phase(r.nxt);
            end else if (p == PhRetCode) begin
              enter_phase(template_kind(tpl) == KOrder ? PhOrderId : PhBlkSkip);
            end else enter_phase(r.nxt);
          end
        end
        OpFix: begin
          if (!nul) begin
            if (b == 0) nul = 1;
            else begin
              have = 1; code = r.code; val = {56'd0, b}; isstr = 1; ci = fbc;
              if (in_item) ii = icnt;
            end
          end
          fbc = fbc + 16'd1;
          if (fbc >= FixedStringBytes) enter_phase(r.nxt);
        end
        OpSkip: begin
          if (skip != 0) skip = skip - 16'd1;
          if (skip == 0) enter_phase(p == PhBlkSkip ? after_block() : r.nxt);
        end
        OpVstr: begin
          have = 1; code = r.code; val = {56'd0, b}; isstr = 1; ci = fbc;
          if (in_item) ii = icnt;
          fbc = fbc + 16'd1;
          if (skip != 0) skip = skip - 16'd1;
          if (skip == 0) enter_phase(p == PhRetMsg ? PhEnd : close_item());
        end
        default: done = 1;
      endcase
      if (err == ErrNone && !done && lst) err = ErrTrunc;
      if (err != ErrNone) begin
        have = 1; done = 1; code = FcError; val = 0; isstr = 0; ci = 0; ii = 0;
      end
      k = template_kind(tpl);
      if ((ph == PhHdr && fbc < 8) || k == KNone) k = KAuth;
      if (have) begin
        w.field_code = code; w.value = val; w.string_byte = isstr; w.char_index = ci;
        w.message_kind = k; w.item_index = ii; w.end_of_message = done; w.error = err;
        results_due.insert(results_due.size(), w);
      end
    end
    if (lst) clear_message();
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (results_due.size() == 0) begin
        fails++;
        $display("%0t: unexpected word, code %0d value %h", $time, field_code, value);
      end else begin
        e = results_due.pop_front();
        if (field_code !== e.field_code || value !== e.value ||
            string_byte !== e.string_byte || char_index !== e.char_index ||
            message_kind !== e.message_kind || item_index !== e.item_index ||
            end_of_message !== e.end_of_message || error !== e.error) begin
          fails++;
          $display("%0t: mismatch exp code %0d val %h str %0d ci %0d kind %0d item %0d eom %0d err %0d",
                   $time, e.field_code, e.value, e.string_byte, e.char_index,
                   e.message_kind, e.item_index, e.end_of_message, e.error);
          $display("%0t:          got code %0d val %h str %0d ci %0d kind %0d item %0d eom %0d err %0d",
                   $time, field_code, value, string_byte, char_index,
                   message_kind, item_index, end_of_message, error);
        end
      end
    end
  end

  // stall the output side at random
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int n;
      n = no_stall ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no traffic for %0d cycles", WatchLimit);
      $display("[sbe_order_response_parser] ERROR");
      $finish;
    end
  end

  // send one byte; called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; data_byte <= b; last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  // hold input until every predicted word has come out
  task automatic drain();
    in_valid <= 0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_schema(input logic [15:0] s);
    drain();
    cfg_we <= 1; cfg_wdata <= s;
    @(negedge clk);
    cfg_we <= 0;
    schema_reg = s;
  endtask

  task automatic put_num(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) msg_bytes.insert(msg_bytes.size(), 8'(v >> (8 * i)));
  endtask

  // fixed string: len characters, then a NUL and junk when shorter than full
  task automatic put_fix(input int len);
    for (int i = 0; i < FixedStringBytes; i++)
      if (i < len) msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(1, 255)));
      else if (i == len) msg_bytes.insert(msg_bytes.size(), 8'h00);
      else msg_bytes.insert(msg_bytes.size(), 8'($urandom));
  endtask

  task automatic put_junk(input int n);
    for (int i = 0; i < n; i++) msg_bytes.insert(msg_bytes.size(), 8'($urandom));
  endtask

  task automatic put_var(input int len);
    put_num(len, 2);
    put_junk(len);
  endtask

  function automatic int fix_len();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return FixedStringBytes;
      default: return $urandom_range(1, FixedStringBytes - 1);
    endcase
  endfunction

  // build one response; blk_adj shifts the block length from its floor
  task automatic build_message(input int t, input logic [15:0] sch, input int blk_adj,
                               input int items, input int item_adj);
    int pad;
    logic [15:0] bl;
    kind_t k;
    k = template_kind(16'(t));
    bl = 16'(int'(block_floor(k)) + blk_adj);
    if (k == KNone) bl = 16'($urandom_range(0, 400));
    pad = (blk_adj > 0) ? blk_adj : 0;
    msg_bytes.delete();
    put_num(bl, 2); put_num(t, 2); put_num(sch, 2); put_junk(2);
    case (k)
      KAuth: begin
        put_fix(fix_len()); put_num({$urandom, $urandom}, 4); put_fix(fix_len());
        put_junk(pad); put_var($urandom_range(0, 6));
      end
      KPong: begin
        put_num({$urandom, $urandom}, 8); put_num({$urandom, $urandom}, 8); put_junk(pad);
      end
      KOrder, KBatch, KCerr: begin
        put_fix(fix_len()); put_fix(fix_len()); put_fix(fix_len());
        repeat (5) put_num({$urandom, $urandom}, 8);
        put_num({$urandom, $urandom}, 4);
        if (k == KOrder) begin put_fix(fix_len()); put_fix(fix_len()); end
        put_junk(pad);
        if (k == KBatch) begin
          put_num(int'(ItemMin) + item_adj, 2); put_num(items, 2);
          for (int i = 0; i < items; i++) begin
            put_num({$urandom, $urandom}, 4); put_num($urandom, 1);
            put_num({$urandom, $urandom}, 8);
            put_fix(fix_len()); put_fix(fix_len());
            if (item_adj > 0) put_junk(item_adj);
            put_var($urandom_range(0, 4));
          end
        end
        put_var($urandom_range(0, 6));
      end
      default: put_junk($urandom_range(0, 20));
    endcase
  endtask

  // send the built message cut to some bytes, with trailing bytes added
  task automatic send_message(input int cut, input int trail);
    if (cut > 0 && cut < msg_bytes.size()) msg_bytes = msg_bytes[0:cut-1];
    put_junk(trail);
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    messages_sent++;
  endtask

  function automatic int random_template();
    case ($urandom_range(0, 9))
      0, 1: return TplAuth;
      2, 3, 4: return TplPong;
      5: return 6 + 2 * $urandom_range(0, 2);
      6, 7: return 12 + 2 * $urandom_range(0, 2);
      8: return TplCerr;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic test_directed();
    build_message(TplAuth, schema_reg, 3, 0, 0); send_message(0, 2);
    build_message(10, schema_reg, 2, 0, 0); send_message(0, 0);
    build_message(16, schema_reg, 1, 1, 2); send_message(0, 0);
    build_message(TplCerr, schema_reg, 0, 0, 0); send_message(20, 0);
    build_message(TplPong, ~schema_reg, 0, 0, 0); send_message(0, 2);
    build_message(3, schema_reg, 0, 0, 0); send_message(0, 0);
    build_message(TplPong, schema_reg, -16, 0, 0); send_message(0, 0);
    // end the message on the item count byte of a too short item block
    build_message(14, schema_reg, 0, 1, -1); send_message(12 + int'(BatchMin), 0);
  endtask

  task automatic test_schema_settings();
    logic [15:0] vals[2];
    vals = '{16'hFFFF, SchemaReset};
    foreach (vals[i]) begin
      write_schema(vals[i]);
      build_message(TplPong, vals[i], 0, 0, 0); send_message(0, 0);
      build_message(TplPong, vals[i] ^ 16'h0100, 0, 0, 0); send_message(0, 0);
    end
  endtask

  task automatic test_pause();
    build_message(TplPong, schema_reg, 5, 0, 0); send_message(0, 0);
    drain();
    build_message(TplPong, schema_reg, 0, 0, 0); send_message(0, 1);
  endtask

  task automatic test_random();
    int t, cut, room, len;
    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 7) == 0) no_stall = ~no_stall;
      t = random_template();
      build_message(t, ($urandom_range(0, 11) == 0) ? 16'($urandom) : schema_reg,
                    ($urandom_range(0, 7) == 0) ? -$urandom_range(1, 20) : $urandom_range(0, 3),
                    $urandom_range(0, 2),
                    ($urandom_range(0, 5) == 0) ? -$urandom_range(1, 3) : $urandom_range(0, 2));
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, msg_bytes.size()) : 0;
      // keep the whole run near its byte budget
      room = ByteCap - bytes_sent;
      len = (cut == 0) ? msg_bytes.size() : cut;
      if (len > room) cut = room;
      send_message(cut, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0);
    end
    no_stall = 0;
  endtask

  initial begin
    schema_reg = SchemaReset;
    clear_message();
    repeat (6) @(negedge clk);
    rst <= 0;
    test_directed();
    test_schema_settings();
    test_pause();
    test_random();
    drain();
    $display("Sent %0d messages in %0d bytes; checked %0d result words", messages_sent,
             bytes_sent, words_seen);
    $display("Covered all templates, error kinds, truncation and schema settings");
    if (fails == 0) $display("[sbe_order_response_parser] OK");
    else $display("[sbe_order_response_parser] ERROR");
    $finish;
  end

endmodule
